@@ hw/rtl/ufsa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufsa_pkg: shared types and constants for the union-find slot allocator
// Slot count, field widths, the per-slot node word and the result beat.
// ----------------------------------------------------------------------------
package ufsa_pkg;

  localparam int SLOT_W = 10;
  localparam int SLOTS  = 1 << SLOT_W;
  localparam int SIZE_W = SLOT_W + 1;

  // one node word per slot: parent link, root size, free slot of the set
  typedef struct packed {
    logic [SLOT_W-1:0] parent;
    logic [SIZE_W-1:0] size;
    logic              free_none;
    logic [SLOT_W-1:0] free_slot;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic valid;
    logic placed;
  } result_t;

endpackage : ufsa_pkg
`default_nettype wire

@@ hw/rtl/ufsa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufsa_ram: simple dual-port synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module ufsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : ufsa_ram
`default_nettype wire

@@ hw/rtl/ufsa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ufsa_ctrl: request sequencer for the union-find slot allocator
// Clears the memories after reset, reads free flags, walks both find paths
// one level per cycle, and writes back the merged or exhausted set.
// ----------------------------------------------------------------------------
module ufsa_ctrl
  import ufsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SLOT_W-1:0] first_slot,
  input  wire logic [SLOT_W-1:0] second_slot,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output result_t                res,
  input  wire logic              out_room
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_FA     = 4'd2;
  localparam logic [3:0] ST_FB     = 4'd3;
  localparam logic [3:0] ST_FIND_D = 4'd4;
  localparam logic [3:0] ST_FIND_N = 4'd5;
  localparam logic [3:0] ST_LINK1  = 4'd6;
  localparam logic [3:0] ST_LINK2  = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]        state;
  logic [SLOT_W-1:0] clr_cnt;
  logic [SLOT_W-1:0] slot_a;
  logic [SLOT_W-1:0] slot_b;
  logic [SLOT_W-1:0] d;
  logic [SLOT_W-1:0] nd;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] rd;
  logic [SLOT_W-1:0] rn;
  node_t             rdw;
  node_t             rnw;
  logic              fa;
  logic              direct;
  logic              retry;
  logic              placed;

  // memory ports
  logic              node_we;
  logic [SLOT_W-1:0] node_waddr;
  node_t             node_wdata;
  logic              node_re;
  logic [SLOT_W-1:0] node_raddr;
  logic [NODE_W-1:0] node_rbits;
  node_t             node_q;
  logic              free_we;
  logic [SLOT_W-1:0] free_waddr;
  logic              free_wdata;
  logic              free_re;
  logic [SLOT_W-1:0] free_raddr;
  logic              free_q;

  logic              at_root;
  logic              fb_direct;
  logic [SLOT_W-1:0] fb_d;
  logic [SLOT_W-1:0] fb_nd;
  logic              same_root;
  logic              rd_bigger;
  logic [SIZE_W-1:0] size_sum;
  node_t             init_word;
  node_t             win_word;

  ufsa_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rbits)
  );

  ufsa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .re    (free_re),
    .raddr (free_raddr),
    .rdata (free_q)
  );

  assign node_q    = node_t'(node_rbits);
  assign at_root   = (node_q.parent == cur);
  assign fb_direct = fa | free_q;
  assign fb_d      = (fa || !free_q) ? slot_a : slot_b;
  assign fb_nd     = (fa || !free_q) ? slot_b : slot_a;
  assign same_root = (rd == rn);
  assign rd_bigger = (rdw.size > rnw.size);
  assign size_sum  = rdw.size + rnw.size;

  assign in_ready   = (state == ST_IDLE);
  assign res.valid  = (state == ST_DONE);
  assign res.placed = placed;

  always_comb begin
    init_word.parent    = clr_cnt;
    init_word.size      = SIZE_W'(1);
    init_word.free_none = 1'b0;
    init_word.free_slot = clr_cnt;

    win_word           = rd_bigger ? rdw : rnw;
    win_word.size      = size_sum;
    win_word.free_none = rnw.free_none;
    win_word.free_slot = rnw.free_slot;
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = rd;
    node_wdata = rdw;
    node_re    = 1'b0;
    node_raddr = nd;
    free_we    = 1'b0;
    free_waddr = fb_d;
    free_wdata = 1'b0;
    free_re    = 1'b0;
    free_raddr = first_slot;
    case (state)
      ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_cnt;
        node_wdata = init_word;
        free_we    = 1'b1;
        free_waddr = clr_cnt;
        free_wdata = 1'b1;
      end
      ST_IDLE: begin
        free_re    = in_valid;
        free_raddr = first_slot;
      end
      ST_FA: begin
        free_re    = 1'b1;
        free_raddr = slot_b;
      end
      ST_FB: begin
        free_we    = fb_direct;
        free_waddr = fb_d;
        node_re    = 1'b1;
        node_raddr = fb_d;
      end
      ST_FIND_D: begin
        if (!at_root) begin
          node_re    = 1'b1;
          node_raddr = node_q.parent;
        end else if (direct) begin
          node_re    = 1'b1;
          node_raddr = nd;
        end else if (node_q.free_none) begin
          // retry with the roles swapped: the new d is the old nd
          node_re    = !retry;
          node_raddr = nd;
        end else begin
          free_we    = 1'b1;
          free_waddr = node_q.free_slot;
          node_re    = 1'b1;
          node_raddr = nd;
        end
      end
      ST_FIND_N: begin
        node_re    = !at_root;
        node_raddr = node_q.parent;
      end
      ST_LINK1: begin
        node_we = 1'b1;
        if (same_root) begin
          node_waddr           = rd;
          node_wdata           = rdw;
          node_wdata.free_none = 1'b1;
          node_wdata.free_slot = '0;
        end else if (rd_bigger) begin
          node_waddr        = rn;
          node_wdata        = rnw;
          node_wdata.parent = rd;
        end else begin
          node_waddr        = rd;
          node_wdata        = rdw;
          node_wdata.parent = rn;
        end
      end
      ST_LINK2: begin
        node_we    = 1'b1;
        node_waddr = rd_bigger ? rd : rn;
        node_wdata = win_word;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      direct  <= 1'b0;
      retry   <= 1'b0;
      placed  <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + SLOT_W'(1);
          if (clr_cnt == SLOT_W'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            slot_a <= first_slot;
            slot_b <= second_slot;
            state  <= ST_FA;
          end
        end
        ST_FA: begin
          fa    <= free_q;
          state <= ST_FB;
        end
        ST_FB: begin
          d      <= fb_d;
          nd     <= fb_nd;
          cur    <= fb_d;
          direct <= fb_direct;
          retry  <= 1'b0;
          state  <= ST_FIND_D;
        end
        ST_FIND_D: begin
          if (!at_root) begin
            cur <= node_q.parent;
          end else if (!direct && node_q.free_none) begin
            if (!retry) begin
              retry <= 1'b1;
              d     <= nd;
              nd    <= d;
              cur   <= nd;
            end else begin
              placed <= 1'b0;
              state  <= ST_DONE;
            end
          end else begin
            rd    <= cur;
            rdw   <= node_q;
            cur   <= nd;
            state <= ST_FIND_N;
          end
        end
        ST_FIND_N: begin
          if (!at_root) begin
            cur <= node_q.parent;
          end else begin
            rn    <= cur;
            rnw   <= node_q;
            state <= ST_LINK1;
          end
        end
        ST_LINK1: begin
          placed <= 1'b1;
          state  <= same_root ? ST_DONE : ST_LINK2;
        end
        ST_LINK2: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_room) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_to_fa: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_FA))
    else $error("accepted beat did not start the free-flag read");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("beat accepted during memory clear");

  a_link2_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINK2) |-> (rd != rn))
    else $error("merge write with equal roots");

  a_reject_path: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.placed) |-> (!direct && retry))
    else $error("reject without exhausting both sets");

endmodule : ufsa_ctrl
`default_nettype wire

@@ hw/rtl/union_find_slot_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_slot_allocator: two-choice slot allocator over a union-find forest
// Places each item in one of two named slots or in its set's free slot.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_ready, first_slot,  | input beat
//           | second_slot                      |
//   out     | out_valid, out_ready, placed     | result beat
//
// One request at a time: the sequencer accepts a beat, reads two free flags,
// walks each find path one node at a time over the node RAM read port, then
// makes up to two link writes and hands off the result. There are up to three
// walks of at most 11 nodes under union by size. After reset a clearing pass
// initializes all 1024 slots of both RAMs; in_ready stays low meanwhile. A held
// result stalls the sequencer only at its end; the output register lets the next
// beat be accepted while a result waits.
// ----------------------------------------------------------------------------
module union_find_slot_allocator
  import ufsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [SLOT_W-1:0] first_slot,
  input  wire logic [SLOT_W-1:0] second_slot,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   placed
);

  result_t res;
  logic    out_room;

  assign out_room = !out_valid || out_ready;

  ufsa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .first_slot  (first_slot),
    .second_slot (second_slot),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .res         (res),
    .out_room    (out_room)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_room && res.valid) begin
      placed <= res.placed;
    end
  end

endmodule : union_find_slot_allocator
`default_nettype wire
